// ===== design/wsfr_pkg.sv =====
// shared types and constants of the websocket frame receiver
package wsfr_pkg;

  // result kinds
  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  // parser phase
  typedef enum logic [1:0] {
    PH_BASE = 2'd0,
    PH_EXT  = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  // error kinds
  localparam logic ERR_PROTOCOL  = 1'b0;
  localparam logic ERR_TOO_LARGE = 1'b1;

  // opcodes
  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_BIN   = 4'h2;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  // 7-bit length codes
  localparam logic [6:0] LEN_EXT16    = 7'd126;
  localparam logic [6:0] LEN_EXT64    = 7'd127;
  localparam logic [6:0] LEN_CTRL_MAX = 7'd125;

  localparam logic [15:0] CLOSE_NO_CODE = 16'd1005;
  localparam logic [63:0] MAX_LEN_RESET = 64'd1048576;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  opcode;
    logic        final_res;
    logic [63:0] payload_length;
    logic [15:0] close_code;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        error_kind;
  } result_t;

  // handshake between parser and the stage registers
  typedef struct packed {
    logic take;
    logic emit;
  } step_t;

endpackage

// ===== design/wsfr_if.sv =====
// stream interfaces for received bytes and parse results
interface wsfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface wsfr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [3:0]  opcode;
  logic        final_res;
  logic [63:0] payload_length;
  logic [15:0] close_code;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic        error_kind;

  modport source (output valid, output kind, output opcode, output final_res,
                  output payload_length, output close_code, output data_byte,
                  output last_byte, output error_kind, input ready);
  modport sink   (input valid, input kind, input opcode, input final_res,
                  input payload_length, input close_code, input data_byte,
                  input last_byte, input error_kind, output ready);
endinterface

// ===== design/wsfr_in_stage.sv =====
// input register holding one received byte
module wsfr_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  wsfr_in_if.sink            in_chan,
  input  wsfr_pkg::step_t    step,
  output logic               byte_vld,
  output logic [7:0]         byte_out
);

  logic       vld_r, vld_nxt;
  logic [7:0] byte_r;
  logic       fire;

  assign in_chan.ready = !vld_r || step.take;
  assign fire          = in_chan.valid && in_chan.ready;
  assign byte_vld      = vld_r;
  assign byte_out      = byte_r;

  always_comb begin
    vld_nxt = vld_r;
    if (fire) begin
      vld_nxt = 1'b1;
    end else if (step.take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      byte_r <= in_chan.rx_byte;
    end
  end

endmodule

// ===== design/wsfr_parser.sv =====
// frame parser state and per-byte decode
module wsfr_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                byte_vld,
  input  logic [7:0]          byte_in,
  input  logic                out_free,
  input  logic [63:0]         max_len,
  output wsfr_pkg::step_t     step,
  output wsfr_pkg::result_t   res
);

  wsfr_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [3:0]  need_r, need_nxt;
  logic [7:0]  b0_r, b0_nxt;
  logic [7:0]  b1_r, b1_nxt;
  logic [63:0] len_r, len_nxt;
  logic [31:0] key_r, key_nxt;
  logic [7:0]  hi_r, hi_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic        halted_r, halted_nxt;

  logic        take, emit, do_finish;
  logic [7:0]  b1_cur;
  logic [3:0]  op;
  logic [6:0]  len7;
  logic        masked, is_ctrl, has_code;
  logic [3:0]  ext, len_end, key_end, need_calc;
  logic        in_len, in_key;
  logic [63:0] len_cur, len_fin;
  logic [7:0]  key_byte;

  assign take      = byte_vld && out_free;
  assign step.take = take;
  assign step.emit = emit;

  // header fields seen so far; byte 1 comes straight from the input on its own step
  assign b1_cur  = (phase_r == wsfr_pkg::PH_BASE) ? byte_in : b1_r;
  assign op      = b0_r[3:0];
  assign len7    = b1_cur[6:0];
  assign masked  = b1_cur[7];
  assign is_ctrl = (op == wsfr_pkg::OP_CLOSE) || (op == wsfr_pkg::OP_PING) ||
                   (op == wsfr_pkg::OP_PONG);
  assign has_code = (op == wsfr_pkg::OP_CLOSE) && (len7 != 7'd0);
  assign ext     = (len7 == wsfr_pkg::LEN_EXT64) ? 4'd8 :
                   (len7 == wsfr_pkg::LEN_EXT16) ? 4'd2 : 4'd0;
  assign len_end = 4'd2 + ext;
  assign key_end = len_end + (masked ? 4'd4 : 4'd0);
  assign need_calc = key_end + ((is_ctrl && has_code) ? 4'd2 : 4'd0);
  assign in_len  = (cnt_r < len_end);
  assign in_key  = !in_len && (cnt_r < key_end);
  assign len_cur = in_len ? {len_r[55:0], byte_in} : len_r;
  assign len_fin = has_code     ? {57'd0, len7 - 7'd2} :
                   (ext == 4'd0) ? {57'd0, len7} : len_cur;
  // key byte m0 sits in bits 31:24, so position p starts at bit 8 * (3 - p)
  assign key_byte = key_r[{~pos_r, 3'b000} +: 8];

  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    need_nxt   = need_r;
    b0_nxt     = b0_r;
    b1_nxt     = b1_r;
    len_nxt    = len_r;
    key_nxt    = key_r;
    hi_nxt     = hi_r;
    rem_nxt    = rem_r;
    pos_nxt    = pos_r;
    halted_nxt = halted_r;
    emit       = 1'b0;
    do_finish  = 1'b0;
    res        = '0;

    if (take && !halted_r) begin
      case (phase_r)
        wsfr_pkg::PH_DATA: begin
          emit          = 1'b1;
          res.kind      = wsfr_pkg::KIND_DATA;
          res.data_byte = byte_in ^ key_byte;
          pos_nxt       = pos_r + 2'd1;
          rem_nxt       = rem_r - 64'd1;
          if (rem_r == 64'd1) begin
            res.last_byte = 1'b1;
            phase_nxt     = wsfr_pkg::PH_BASE;
            cnt_nxt       = 4'd0;
          end
        end
        wsfr_pkg::PH_BASE: begin
          if (cnt_r == 4'd0) begin
            b0_nxt  = byte_in;
            cnt_nxt = 4'd1;
          end else begin
            b1_nxt  = byte_in;
            len_nxt = '0;
            key_nxt = '0;
            cnt_nxt = 4'd2;
            if (is_ctrl && ((b0_r[6:4] != 3'd0) || (len7 > wsfr_pkg::LEN_CTRL_MAX) ||
                            ((op == wsfr_pkg::OP_CLOSE) && (len7 == 7'd1)))) begin
              emit           = 1'b1;
              halted_nxt     = 1'b1;
              res.kind       = wsfr_pkg::KIND_ERROR;
              res.error_kind = wsfr_pkg::ERR_PROTOCOL;
            end else begin
              need_nxt  = need_calc;
              phase_nxt = wsfr_pkg::PH_EXT;
              do_finish = (need_calc == 4'd2);
            end
          end
        end
        wsfr_pkg::PH_EXT: begin
          cnt_nxt = cnt_r + 4'd1;
          if (in_len) begin
            len_nxt = len_cur;
          end else if (in_key) begin
            key_nxt = {key_r[23:0], byte_in};
          end else begin
            hi_nxt = byte_in ^ key_r[31:24];
          end
          do_finish = (cnt_r + 4'd1 == need_r);
        end
        default: begin
          phase_nxt = wsfr_pkg::PH_BASE;
          cnt_nxt   = 4'd0;
        end
      endcase

      if (do_finish) begin
        emit = 1'b1;
        if (len_fin > max_len) begin
          halted_nxt     = 1'b1;
          res.kind       = wsfr_pkg::KIND_ERROR;
          res.error_kind = wsfr_pkg::ERR_TOO_LARGE;
        end else if ((b0_r[6:4] != 3'd0) ||
                     !((op == wsfr_pkg::OP_CONT) || (op == wsfr_pkg::OP_TEXT) ||
                       (op == wsfr_pkg::OP_BIN) || is_ctrl)) begin
          halted_nxt     = 1'b1;
          res.kind       = wsfr_pkg::KIND_ERROR;
          res.error_kind = wsfr_pkg::ERR_PROTOCOL;
        end else begin
          res.kind           = wsfr_pkg::KIND_HEADER;
          res.opcode         = op;
          res.final_res      = b0_r[7];
          res.payload_length = len_fin;
          if (op == wsfr_pkg::OP_CLOSE) begin
            res.close_code = has_code ? {hi_r, byte_in ^ key_r[23:16]}
                                      : wsfr_pkg::CLOSE_NO_CODE;
          end
          if (len_fin == 64'd0) begin
            phase_nxt = wsfr_pkg::PH_BASE;
            cnt_nxt   = 4'd0;
          end else begin
            phase_nxt = wsfr_pkg::PH_DATA;
            rem_nxt   = len_fin;
            pos_nxt   = has_code ? 2'd2 : 2'd0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= wsfr_pkg::PH_BASE;
      cnt_r    <= 4'd0;
      need_r   <= 4'd2;
      len_r    <= '0;
      key_r    <= '0;
      rem_r    <= '0;
      pos_r    <= 2'd0;
      halted_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      need_r   <= need_nxt;
      len_r    <= len_nxt;
      key_r    <= key_nxt;
      rem_r    <= rem_nxt;
      pos_r    <= pos_nxt;
      halted_r <= halted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b0_r <= b0_nxt;
    b1_r <= b1_nxt;
    hi_r <= hi_nxt;
  end

endmodule

// ===== design/wsfr_out_stage.sv =====
// result register toward the consumer
module wsfr_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  wsfr_pkg::step_t     step,
  input  wsfr_pkg::result_t   res,
  output logic                out_free,
  wsfr_out_if.source          out_chan
);

  logic              vld_r, vld_nxt;
  wsfr_pkg::result_t res_r;

  assign out_free = !vld_r || out_chan.ready;

  always_comb begin
    vld_nxt = vld_r;
    if (step.emit) begin
      vld_nxt = 1'b1;
    end else if (out_chan.ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step.emit) begin
      res_r <= res;
    end
  end

  assign out_chan.valid          = vld_r;
  assign out_chan.kind           = res_r.kind;
  assign out_chan.opcode         = res_r.opcode;
  assign out_chan.final_res      = res_r.final_res;
  assign out_chan.payload_length = res_r.payload_length;
  assign out_chan.close_code     = res_r.close_code;
  assign out_chan.data_byte      = res_r.data_byte;
  assign out_chan.last_byte      = res_r.last_byte;
  assign out_chan.error_kind     = res_r.error_kind;

endmodule

// ===== design/websocket_frame_receiver.sv =====
// top level of the websocket frame receiver
// Receive-side websocket frame parser: one link byte per request on in_chan, one result
// per request on out_chan at most. The block sustains a byte every cycle while out_chan
// is ready. The input register takes a byte, decode runs combinationally between the
// registers and the result register takes its result at the next edge, from which it is
// offered on out_chan. While a result waits on out_chan decode holds, so the input also
// stalls on header bytes that give no result. A result is a header event (opcode, fin,
// length, close code), an unmasked payload byte with a last mark, or an error; after an
// error every further byte is taken and dropped until reset. The user must write
// max_payload_length through cfg_we / cfg_wdata only while the block is idle; the block
// does not enforce this. max_payload_length resets to 1048576.
module websocket_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  wsfr_in_if.sink     in_chan,
  wsfr_out_if.source  out_chan,
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata
);

  // largest accepted payload length
  logic [63:0] max_len_r;

  wsfr_pkg::step_t   step;
  wsfr_pkg::result_t res;
  logic              byte_vld;
  logic [7:0]        byte_q;
  logic              out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= wsfr_pkg::MAX_LEN_RESET;
    end else if (cfg_we) begin
      max_len_r <= cfg_wdata;
    end
  end

  // byte register, frees up in the same cycle its byte is decoded
  wsfr_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .step     (step),
    .byte_vld (byte_vld),
    .byte_out (byte_q)
  );

  // header decode, length and key capture, payload unmasking
  wsfr_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_vld (byte_vld),
    .byte_in  (byte_q),
    .out_free (out_free),
    .max_len  (max_len_r),
    .step     (step),
    .res      (res)
  );

  // result register, decode only moves when it can take a result
  wsfr_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .res      (res),
    .out_free (out_free),
    .out_chan (out_chan)
  );

endmodule

// ===== design/wsfr_checker.sv =====
// port-level checks of the frame receiver and their binding
module wsfr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [3:0]  out_opcode,
  input logic [63:0] out_payload_length,
  input logic [15:0] out_close_code,
  input logic [7:0]  out_data_byte,
  input logic        out_last_byte
);

  // a stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data_byte) && $stable(out_payload_length))
    else $error("result changed while stalled");

  // nothing follows a taken error
  a_halt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && (out_kind == wsfr_pkg::KIND_ERROR) |=> !out_valid)
    else $error("result after error");

  a_last_is_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_byte |-> (out_kind == wsfr_pkg::KIND_DATA))
    else $error("last mark on non-payload result");

  a_code_close_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_close_code != 16'd0) |->
      (out_kind == wsfr_pkg::KIND_HEADER) && (out_opcode == wsfr_pkg::OP_CLOSE))
    else $error("close code outside close header");

endmodule

bind websocket_frame_receiver wsfr_checker u_wsfr_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_chan.valid),
  .out_ready          (out_chan.ready),
  .out_kind           (out_chan.kind),
  .out_opcode         (out_chan.opcode),
  .out_payload_length (out_chan.payload_length),
  .out_close_code     (out_chan.close_code),
  .out_data_byte      (out_chan.data_byte),
  .out_last_byte      (out_chan.last_byte)
);
